/* sv/assert_macros.svh */
// Concurrent assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define OGSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OGSC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ogsc_pkg.sv */
package ogsc_pkg;

    localparam int DATA_W    = 16;
    localparam int SUM_W     = 20;
    localparam int CNT_W     = 4;
    localparam int Q_SHIFT   = 8;
    localparam int DIV_W     = DATA_W + Q_SHIFT;
    localparam int STATUS_W  = 3;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] GAIN_UNITY = 16'd256;
    localparam logic [DATA_W-1:0] FULL16     = 16'hFFFF;

    localparam logic [DATA_W-1:0] MIN_DELTA_RST    = 16'd1;
    localparam logic [DATA_W-1:0] REF_DELTA_RST    = 16'd256;
    localparam logic [DATA_W-1:0] RECORD_MAGIC_RST = 16'd0;

    typedef enum logic [OP_W-1:0] {
        OP_CORRECT = 2'd0,
        OP_CAPTURE = 2'd1,
        OP_SMOKE   = 2'd2,
        OP_LOAD    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE        = 3'd0,
        ST_SMOKE_TAKEN = 3'd1,
        ST_GAIN_SET    = 3'd2,
        ST_REJECTED    = 3'd3,
        ST_REC_VALID   = 3'd4,
        ST_REC_INVALID = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DELTA    = 2'd0,
        CFG_REF_DELTA    = 2'd1,
        CFG_RECORD_MAGIC = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_DIV_GAIN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic check;
        logic start_gain;
        logic commit;
    } ogsc_cmd_t;

    typedef struct packed {
        op_t  op;
        logic last_smoke;
        logic div_needed;
        logic div_done;
        logic out_free;
    } ogsc_stat_t;

endpackage

/* sv/ogsc_in_if.sv */
interface ogsc_in_if;
    logic                       valid;
    logic                       ready;
    logic [ogsc_pkg::OP_W-1:0]  op;
    logic [ogsc_pkg::DATA_W-1:0] sample;
    logic [ogsc_pkg::DATA_W-1:0] rec_magic;
    logic [ogsc_pkg::DATA_W-1:0] rec_baseline;
    logic [ogsc_pkg::DATA_W-1:0] rec_gain;
    logic [ogsc_pkg::DATA_W-1:0] rec_check;

    modport source (
        output valid, op, sample, rec_magic, rec_baseline, rec_gain, rec_check,
        input  ready
    );

    modport sink (
        input  valid, op, sample, rec_magic, rec_baseline, rec_gain, rec_check,
        output ready
    );
endinterface

/* sv/ogsc_out_if.sv */
interface ogsc_out_if;
    logic                          valid;
    logic                          ready;
    logic [ogsc_pkg::DATA_W-1:0]   corrected;
    logic [ogsc_pkg::STATUS_W-1:0] status;
    logic [ogsc_pkg::DATA_W-1:0]   gain_now;
    logic [ogsc_pkg::DATA_W-1:0]   baseline_now;
    logic                          smoke_pending;

    modport source (
        output valid, corrected, status, gain_now, baseline_now, smoke_pending,
        input  ready
    );

    modport sink (
        input  valid, corrected, status, gain_now, baseline_now, smoke_pending,
        output ready
    );
endinterface

/* sv/ogsc_div.sv */
module ogsc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ogsc_pkg::DIV_W-1:0]   dividend,
    input  logic [ogsc_pkg::DATA_W-1:0]  divisor,
    output logic                         done,
    output logic [ogsc_pkg::DIV_W-1:0]   quot
);
    localparam int DW   = ogsc_pkg::DIV_W;
    localparam int VW   = ogsc_pkg::DATA_W;
    localparam int CW   = $clog2(DW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [VW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] dsr_reg;

    logic [VW:0]   partial;
    logic [VW:0]   trial;
    logic          ge;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        partial = {rem_reg, quo_reg[DW-1]};
        ge      = partial >= {1'b0, dsr_reg};
        trial   = partial - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial[VW-1:0] : partial[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
endmodule

/* sv/ogsc_ctrl.sv */
module ogsc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  ogsc_pkg::ogsc_stat_t stat,
    output logic                 in_ready,
    output ogsc_pkg::ogsc_cmd_t  cmd
);
    ogsc_pkg::state_t state_reg;
    ogsc_pkg::state_t state_next;

    logic smoke_div;

    assign smoke_div = (stat.op == ogsc_pkg::OP_SMOKE) && stat.last_smoke;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ogsc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ogsc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ogsc_pkg::S_EXEC;
                end
            end
            ogsc_pkg::S_EXEC:
            begin
                state_next = smoke_div ? ogsc_pkg::S_CHECK : ogsc_pkg::S_FINISH;
            end
            ogsc_pkg::S_CHECK:
            begin
                state_next = stat.div_needed ? ogsc_pkg::S_DIV_GAIN : ogsc_pkg::S_FINISH;
            end
            ogsc_pkg::S_DIV_GAIN:
            begin
                if (stat.div_done)
                begin
                    state_next = ogsc_pkg::S_FINISH;
                end
            end
            ogsc_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ogsc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ogsc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            ogsc_pkg::S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            ogsc_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ogsc_pkg::S_CHECK:
            begin
                cmd.check      = 1'b1;
                cmd.start_gain = stat.div_needed;
            end
            ogsc_pkg::S_FINISH:
            begin
                cmd.commit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end
endmodule

/* sv/ogsc_datapath.sv */
module ogsc_datapath #(
    parameter int SMOKE_SAMPLES = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ogsc_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [ogsc_pkg::DATA_W-1:0]       cfg_wdata,
    input  logic [ogsc_pkg::OP_W-1:0]         in_op,
    input  logic [ogsc_pkg::DATA_W-1:0]       in_sample,
    input  logic [ogsc_pkg::DATA_W-1:0]       in_rec_magic,
    input  logic [ogsc_pkg::DATA_W-1:0]       in_rec_baseline,
    input  logic [ogsc_pkg::DATA_W-1:0]       in_rec_gain,
    input  logic [ogsc_pkg::DATA_W-1:0]       in_rec_check,
    input  ogsc_pkg::ogsc_cmd_t               cmd,
    output ogsc_pkg::ogsc_stat_t              stat,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [ogsc_pkg::DATA_W-1:0]       out_corrected,
    output logic [ogsc_pkg::STATUS_W-1:0]     out_status,
    output logic [ogsc_pkg::DATA_W-1:0]       out_gain_now,
    output logic [ogsc_pkg::DATA_W-1:0]       out_baseline_now,
    output logic                              out_smoke_pending
);
    localparam int DW = ogsc_pkg::DATA_W;
    localparam int SW = ogsc_pkg::SUM_W;
    localparam int CW = ogsc_pkg::CNT_W;
    localparam int QS = ogsc_pkg::Q_SHIFT;
    localparam int VW = ogsc_pkg::DIV_W;

    // batch mean by reciprocal multiply, exact for any SW-bit sum
    localparam int     MW         = SW + 1;
    localparam int     MEAN_SH    = SW + $clog2(SMOKE_SAMPLES);
    localparam longint MEAN_MUL_L = ((longint'(1) << MEAN_SH) + longint'(SMOKE_SAMPLES) - 1)
                                    / longint'(SMOKE_SAMPLES);
    localparam logic [MW-1:0] MEAN_MUL = MW'(MEAN_MUL_L);

    // config
    logic [DW-1:0] min_delta_reg;
    logic [DW-1:0] ref_delta_reg;
    logic [DW-1:0] record_magic_reg;

    // latched item
    ogsc_pkg::op_t op_reg;
    logic [DW-1:0] sample_reg;
    logic [DW-1:0] rmagic_reg;
    logic [DW-1:0] rbase_reg;
    logic [DW-1:0] rgain_reg;
    logic [DW-1:0] rcheck_reg;

    // calibration state
    logic [DW-1:0] baseline_reg;
    logic [DW-1:0] baseline_next;
    logic [DW-1:0] gain_reg;
    logic [DW-1:0] gain_next;
    logic          pend_reg;
    logic          pend_next;
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] sum_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    // working registers
    logic [2*DW-1:0] prod_reg;
    logic [DW-1:0]   mean_reg;
    logic            rej_reg;
    logic            dzero_reg;

    // result register
    logic                          out_valid_reg;
    logic [DW-1:0]                 corr_reg;
    ogsc_pkg::status_t             st_reg;
    logic [DW-1:0]                 gain_out_reg;
    logic [DW-1:0]                 base_out_reg;
    logic                          pend_out_reg;

    logic [DW-1:0]       corr_next;
    ogsc_pkg::status_t   st_next;

    logic [SW-1:0]    sum_add;
    logic [SW+MW-1:0] mean_prod;
    logic [DW-1:0]    diff;
    logic [DW-1:0]    delta;
    logic             delta_low;
    logic             last_smoke;
    logic             rec_ok;
    logic [DW-1:0]    rec_gain_sel;
    logic [DW-1:0]    calc_gain;
    logic [DW-1:0]    corr_sat;

    logic          div_start;
    logic [VW-1:0] div_dividend;
    logic [DW-1:0] div_divisor;
    logic          div_done;
    logic [VW-1:0] div_quot;

    always_comb
    begin
        sum_add    = sum_reg + SW'(sample_reg);
        mean_prod  = sum_add * MEAN_MUL;
        diff       = (sample_reg > baseline_reg) ? (sample_reg - baseline_reg) : '0;
        delta      = (mean_reg > baseline_reg) ? (mean_reg - baseline_reg) : '0;
        delta_low  = delta < min_delta_reg;
        last_smoke = ({1'b0, cnt_reg} + (CW+1)'(1)) >= (CW+1)'(SMOKE_SAMPLES);
        rec_ok     = (rmagic_reg == record_magic_reg)
                     && (rcheck_reg == (rmagic_reg ^ rbase_reg ^ rgain_reg))
                     && (rgain_reg != '0);
        rec_gain_sel = rec_ok ? rgain_reg : ogsc_pkg::GAIN_UNITY;
        calc_gain  = (dzero_reg || (|div_quot[VW-1:DW])) ? ogsc_pkg::FULL16
                                                          : div_quot[DW-1:0];
        corr_sat   = (|prod_reg[2*DW-1:DW+QS]) ? ogsc_pkg::FULL16
                                                : prod_reg[DW+QS-1:QS];
    end

    assign div_start    = cmd.start_gain;
    assign div_dividend = {ref_delta_reg, {QS{1'b0}}};
    assign div_divisor  = delta;

    ogsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_delta_reg    <= ogsc_pkg::MIN_DELTA_RST;
            ref_delta_reg    <= ogsc_pkg::REF_DELTA_RST;
            record_magic_reg <= ogsc_pkg::RECORD_MAGIC_RST;
        end
        else if (cfg_we)
        begin
            case (ogsc_pkg::cfg_idx_t'(cfg_idx))
                ogsc_pkg::CFG_MIN_DELTA:    min_delta_reg    <= cfg_wdata;
                ogsc_pkg::CFG_REF_DELTA:    ref_delta_reg    <= cfg_wdata;
                ogsc_pkg::CFG_RECORD_MAGIC: record_magic_reg <= cfg_wdata;
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg     <= ogsc_pkg::op_t'(in_op);
            sample_reg <= in_sample;
            rmagic_reg <= in_rec_magic;
            rbase_reg  <= in_rec_baseline;
            rgain_reg  <= in_rec_gain;
            rcheck_reg <= in_rec_check;
        end
        if (cmd.exec)
        begin
            prod_reg <= diff * gain_reg;
            mean_reg <= mean_prod[MEAN_SH +: DW];
        end
        if (cmd.check)
        begin
            rej_reg   <= delta_low;
            dzero_reg <= delta == '0;
        end
    end

    always_comb
    begin
        baseline_next = baseline_reg;
        gain_next     = gain_reg;
        pend_next     = pend_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        corr_next     = '0;
        st_next       = ogsc_pkg::ST_DONE;
        if (cmd.exec && (op_reg == ogsc_pkg::OP_SMOKE))
        begin
            sum_next = sum_add;
        end
        if (cmd.commit)
        begin
            case (op_reg)
                ogsc_pkg::OP_CORRECT:
                begin
                    corr_next = corr_sat;
                end
                ogsc_pkg::OP_CAPTURE:
                begin
                    baseline_next = sample_reg;
                    gain_next     = ogsc_pkg::GAIN_UNITY;
                    pend_next     = 1'b1;
                    sum_next      = '0;
                    cnt_next      = '0;
                end
                ogsc_pkg::OP_SMOKE:
                begin
                    if (!last_smoke)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                        st_next  = ogsc_pkg::ST_SMOKE_TAKEN;
                    end
                    else
                    begin
                        sum_next = '0;
                        cnt_next = '0;
                        if (rej_reg)
                        begin
                            pend_next = 1'b1;
                            st_next   = ogsc_pkg::ST_REJECTED;
                        end
                        else
                        begin
                            gain_next = calc_gain;
                            pend_next = 1'b0;
                            st_next   = ogsc_pkg::ST_GAIN_SET;
                        end
                    end
                end
                ogsc_pkg::OP_LOAD:
                begin
                    sum_next      = '0;
                    cnt_next      = '0;
                    baseline_next = rec_ok ? rbase_reg : '0;
                    gain_next     = rec_gain_sel;
                    pend_next     = rec_gain_sel == ogsc_pkg::GAIN_UNITY;
                    st_next       = rec_ok ? ogsc_pkg::ST_REC_VALID
                                           : ogsc_pkg::ST_REC_INVALID;
                end
                default:
                begin
                    corr_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg  <= '0;
            gain_reg      <= ogsc_pkg::GAIN_UNITY;
            pend_reg      <= 1'b0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            baseline_reg <= baseline_next;
            gain_reg     <= gain_next;
            pend_reg     <= pend_next;
            sum_reg      <= sum_next;
            cnt_reg      <= cnt_next;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            corr_reg     <= corr_next;
            st_reg       <= st_next;
            gain_out_reg <= gain_next;
            base_out_reg <= baseline_next;
            pend_out_reg <= pend_next;
        end
    end

    assign stat.op         = op_reg;
    assign stat.last_smoke = last_smoke;
    assign stat.div_needed = !delta_low && (delta != '0);
    assign stat.div_done   = div_done;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid         = out_valid_reg;
    assign out_corrected     = corr_reg;
    assign out_status        = st_reg;
    assign out_gain_now      = gain_out_reg;
    assign out_baseline_now  = base_out_reg;
    assign out_smoke_pending = pend_out_reg;
endmodule

/* sv/offset_gain_sensor_calibrator_core.sv */
// Offset and gain calibrator for a 16-bit sensor, one result transaction per input
// transaction. Correct, capture, load and non-final smoke items go through EXEC
// and FINISH from acceptance to result. The smoke item that closes a batch forms
// its mean with a reciprocal multiply and goes through EXEC, CHECK and FINISH when
// the batch is rejected or the delta is zero, else also through DIV_GAIN while a
// 24-step restoring divider computes the new gain. A new input is taken as soon as
// the previous result sits in the output register, even if the sink has not yet
// taken it; the next result then waits in FINISH until that register is free.
module offset_gain_sensor_calibrator_core #(
    parameter int SMOKE_SAMPLES = 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ogsc_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [ogsc_pkg::DATA_W-1:0]    cfg_wdata,
    ogsc_in_if.sink                        in_ch,
    ogsc_out_if.source                     out_ch
);
    ogsc_pkg::ogsc_cmd_t  cmd;
    ogsc_pkg::ogsc_stat_t stat;
    logic                 in_ready;

    assign in_ch.ready = in_ready;

    ogsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    ogsc_datapath #(
        .SMOKE_SAMPLES (SMOKE_SAMPLES)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_idx           (cfg_idx),
        .cfg_wdata         (cfg_wdata),
        .in_op             (in_ch.op),
        .in_sample         (in_ch.sample),
        .in_rec_magic      (in_ch.rec_magic),
        .in_rec_baseline   (in_ch.rec_baseline),
        .in_rec_gain       (in_ch.rec_gain),
        .in_rec_check      (in_ch.rec_check),
        .cmd               (cmd),
        .stat              (stat),
        .out_ready         (out_ch.ready),
        .out_valid         (out_ch.valid),
        .out_corrected     (out_ch.corrected),
        .out_status        (out_ch.status),
        .out_gain_now      (out_ch.gain_now),
        .out_baseline_now  (out_ch.baseline_now),
        .out_smoke_pending (out_ch.smoke_pending)
    );
endmodule

/* sv/ogsc_checker.sv */
`include "assert_macros.svh"

module ogsc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [ogsc_pkg::DATA_W-1:0]   corrected,
    input logic [ogsc_pkg::STATUS_W-1:0] status,
    input logic [ogsc_pkg::DATA_W-1:0]   gain_now,
    input logic [ogsc_pkg::DATA_W-1:0]   baseline_now,
    input logic                          smoke_pending
);
    `OGSC_ASSERT_IMP(a_corr_only_done, clk, rst_n, out_valid && (status != ogsc_pkg::ST_DONE), corrected == '0, "nonzero corrected value on non-correct transaction")
    `OGSC_ASSERT_IMP(a_gain_set_clears, clk, rst_n, out_valid && (status == ogsc_pkg::ST_GAIN_SET), !smoke_pending, "pending flag left set after gain calibration")
    `OGSC_ASSERT_IMP(a_rec_invalid_dflt, clk, rst_n, out_valid && (status == ogsc_pkg::ST_REC_INVALID), (gain_now == ogsc_pkg::GAIN_UNITY) && (baseline_now == '0) && smoke_pending, "invalid record did not install defaults")
    `OGSC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(corrected) && $stable(gain_now), "stalled result changed")
endmodule

bind offset_gain_sensor_calibrator_core ogsc_checker u_ogsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .corrected     (out_ch.corrected),
    .status        (out_ch.status),
    .gain_now      (out_ch.gain_now),
    .baseline_now  (out_ch.baseline_now),
    .smoke_pending (out_ch.smoke_pending)
);
